/* sv/mshash_pkg.sv */
// Shared constants, types and helper functions for the stream hash block.
package mshash_pkg;

    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] MIX_ADD    = 32'he6546b64;
    localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET = 32'd20000033;

    localparam int unsigned ROT_K = 15;
    localparam int unsigned ROT_H = 13;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_SEED = 3'd0;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [2:0] CNT_FULL = 3'd4;
    localparam logic [2:0] CNT_ONE  = 3'd1;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_NONE = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_FOLD,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mix;
        logic fold;
        logic fin1;
        logic fin2;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[31-ROT_K:0], x[31:32-ROT_K]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[31-ROT_H:0], x[31:32-ROT_H]};
    endfunction

endpackage

/* sv/murmur_style_stream_hash32.sv */
// Each accepted word is stepped through the two mix multiplies and then folded into the hash;
// a last word then passes the two finalizer steps and shows its hash on m_tvalid once the output is free.
// A word is accepted only while the sequencer is idle, so the block takes no new word until it has
// finished the previous one, including any wait for the output to be free.
// Reset: synchronous active-low aresetn returns to idle, drops m_tvalid,
// clears the byte length and reloads seed to 20000033.
module murmur_style_stream_hash32 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: data_word [31:0], byte_count [34:32], zero pad [39:35]
    input  logic [mshash_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: hash_value [31:0]
    output logic [mshash_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mshash_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mshash_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic        cfg_write;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_SEED);
    assign seed_next = cfg_write ? pwdata : seed_reg;
    assign prdata    = (paddr == ADDR_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

    mshash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mshash_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .seed      (seed_reg),
        .in_word   (s_tdata[31:0]),
        .in_count  (s_tdata[34:32]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (m_tdata)
    );

endmodule

/* sv/mshash_ctrl.sv */
// Sequencer that steps one key word through mixing and folding and, for a last word, finalizing.
module mshash_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output mshash_pkg::dp_cmd_t   cmd,
    input  mshash_pkg::dp_status_t status
);
    import mshash_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:  state_next = ST_FOLD;
            ST_FOLD: begin
                state_next = status.last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: state_next = ST_EMIT;
            ST_EMIT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MIX:  cmd.mix  = 1'b1;
            ST_FOLD: cmd.fold = 1'b1;
            ST_FIN1: cmd.fin1 = 1'b1;
            ST_FIN2: cmd.fin2 = 1'b1;
            ST_EMIT: cmd.emit = status.out_free;
            default: cmd      = '0;
        endcase
    end

`ifndef SYNTH
    a_load_to_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_MIX))
        else $error("accepted word did not enter mixing");
    a_fold_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |=> (state_reg == ST_IDLE || state_reg == ST_FIN1))
        else $error("fold left to an unexpected state");
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("emit did not return to idle");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("ready raised outside idle");
`endif

endmodule

/* sv/mshash_dp.sv */
// Datapath: word mixing, hash fold, length count, finalizer and output register.
module mshash_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mshash_pkg::dp_cmd_t    cmd,
    output mshash_pkg::dp_status_t status,
    input  logic [31:0]            seed,
    input  logic [31:0]            in_word,
    input  logic [2:0]             in_count,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            out_hash
);
    import mshash_pkg::*;

    logic [31:0] word_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic [31:0] k_reg;
    logic [31:0] acc_reg;
    logic [31:0] len_reg;
    logic        in_key_reg;
    logic        in_key_next;
    logic [31:0] fin_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [2:0]  cnt_clamped;
    logic [31:0] base_h;
    logic [31:0] rot_h;
    logic [31:0] tail;
    logic [31:0] fold_h;
    logic [31:0] len_sum;
    logic [31:0] fin1_pre;
    logic [31:0] fin2_pre;

    // byte counts above four mean a full word
    assign cnt_clamped = in_count[2] ? CNT_FULL : in_count;

    assign base_h  = in_key_reg ? acc_reg : seed;
    assign rot_h   = rotl13(base_h ^ k_reg);
    assign len_sum = len_reg + {29'd0, cnt_reg};

    always_comb begin
        case (cnt_reg)
            CNT_ONE:   tail = {24'd0, word_reg[7:0]};
            CNT_TWO:   tail = {16'd0, word_reg[15:0]};
            CNT_THREE: tail = {8'd0, word_reg[23:0]};
            default:   tail = '0;
        endcase
    end

    always_comb begin
        case (cnt_reg)
            CNT_FULL: fold_h = {rot_h[29:0], 2'b00} + rot_h + MIX_ADD;
            CNT_NONE: fold_h = base_h;
            default:  fold_h = base_h ^ {tail[15:0], tail[31:16]};
        endcase
    end

    assign fin1_pre = fin_reg ^ {16'd0, fin_reg[31:16]};
    assign fin2_pre = fin_reg ^ {13'd0, fin_reg[31:13]};

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg <= in_word;
            cnt_reg  <= cnt_clamped;
            last_reg <= in_last;
            k_reg    <= in_word * MIX_C1;
        end
        if (cmd.mix) begin
            k_reg <= rotl15(k_reg) * MIX_C2;
        end
        if (cmd.fold) begin
            acc_reg <= fold_h;
            fin_reg <= fold_h ^ len_sum;
        end
        if (cmd.fin1) begin
            fin_reg <= fin1_pre * FIN_M1;
        end
        if (cmd.fin2) begin
            fin_reg <= fin2_pre * FIN_M2;
        end
        if (cmd.emit) begin
            out_reg <= fin_reg ^ {16'd0, fin_reg[31:16]};
        end
    end

    always_comb begin
        in_key_next = in_key_reg;
        if (cmd.fold) begin
            in_key_next = !last_reg;
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            in_key_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.fold) begin
                len_reg <= last_reg ? 32'd0 : len_sum;
            end
            in_key_reg    <= in_key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_hash        = out_reg;

`ifndef SYNTH
    a_key_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fold && last_reg) |=> (len_reg == 32'd0 && !in_key_reg))
        else $error("key state not cleared after last word");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken result");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed or dropped");
`endif

endmodule
